@@ design/bdq_pkg.sv @@
// Shared types, sizes and the ring index helper for the bounded deque.
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 5;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - DATA_W - POS_W;
  localparam int OUT_TDATA_W = ((DATA_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - LEN_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_DUMP      = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DUMP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     load;
    logic signed [DATA_W-1:0] item;
    status_t                  status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } result_t;

  // Slot of the element k places behind the front, wrapping around the ring.
  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] front,
                                             input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(k);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return AW'(sum);
  endfunction

endpackage

@@ design/bdq_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/bdq_out.sv @@
// Result register between the sequencer and the output stream.
module bdq_out import bdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  result_t                  res,
  output logic                     out_free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_item,
  output status_t                  out_status,
  output logic [LEN_W-1:0]         out_length,
  output logic                     out_last
);

  logic                     valid_r;
  logic signed [DATA_W-1:0] item_r;
  status_t                  status_r;
  logic [LEN_W-1:0]         length_r;
  logic                     last_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      item_r   <= res.item;
      status_r <= res.status;
      length_r <= res.length;
      last_r   <= res.last;
    end
  end

  assign out_valid  = valid_r;
  assign out_item   = item_r;
  assign out_status = status_r;
  assign out_length = length_r;
  assign out_last   = last_r;

endmodule

@@ design/bdq_ctrl.sv @@
// Command sequencer: ring pointers, slot memory accesses and result generation.
module bdq_ctrl import bdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cmd_t                     in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_pos,
  input  logic                     out_free,
  output result_t                  res,
  output mem_req_t                 mem,
  input  logic [DATA_W-1:0]        rd_data
);

  state_t           state_r, state_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             pend_r, pend_nxt;
  status_t          status_r, status_nxt;

  logic             empty, full, range_bad, del_shift, shift_more;
  logic             dump_load, dump_last, dump_issue;
  logic [CNT_W-1:0] pos_k;
  logic [AW-1:0]    front_dec;

  assign in_ready   = (state_r == ST_IDLE);
  assign empty      = (occ_r == '0);
  assign full       = (occ_r == CNT_W'(CAPACITY));
  assign range_bad  = (in_pos >= POS_W'(occ_r));
  assign pos_k      = CNT_W'(in_pos);
  assign del_shift  = !empty && !range_bad && ((pos_k + CNT_W'(1)) != occ_r);
  assign shift_more = ((k_r + CNT_W'(2)) < occ_r);
  assign dump_load  = pend_r && out_free;
  assign dump_last  = (k_r == occ_r);
  assign dump_issue = (k_r < occ_r) && (!pend_r || dump_load);
  assign front_dec  = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - AW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_DELETE && del_shift) begin
            state_nxt = ST_SHIFT;
          end else if (in_cmd == CMD_DUMP && !empty) begin
            state_nxt = ST_DUMP;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = ST_RESP;
        end
      end
      ST_DUMP: begin
        if (dump_load && dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    mem        = '0;
    res        = '0;
    res.length = LEN_W'(occ_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd) inside
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                status_nxt = STAT_OK;
                mem.we     = 1'b1;
                mem.wdata  = in_value;
                occ_nxt    = occ_r + CNT_W'(1);
                if (in_cmd == CMD_INS_FRONT) begin
                  front_nxt = front_dec;
                  mem.waddr = front_dec;
                end else begin
                  mem.waddr = ring_idx(front_r, occ_r);
                end
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else if (range_bad) begin
                status_nxt = STAT_RANGE;
              end else begin
                status_nxt = STAT_OK;
                if (del_shift) begin
                  // Fetch the successor of the deleted element.
                  mem.re    = 1'b1;
                  mem.raddr = ring_idx(front_r, pos_k + CNT_W'(1));
                  k_nxt     = pos_k;
                end else begin
                  occ_nxt = occ_r - CNT_W'(1);
                end
              end
            end
            default: begin
              status_nxt = empty ? STAT_EMPTY : STAT_OK;
              k_nxt      = '0;
              pend_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Move slot k+1 down to k and, while more slots remain, fetch k+2 in the same cycle.
        mem.we    = 1'b1;
        mem.waddr = ring_idx(front_r, k_r);
        mem.wdata = rd_data;
        if (shift_more) begin
          mem.re    = 1'b1;
          mem.raddr = ring_idx(front_r, k_r + CNT_W'(2));
          k_nxt     = k_r + CNT_W'(1);
        end else begin
          occ_nxt = occ_r - CNT_W'(1);
        end
      end
      ST_DUMP: begin
        mem.re    = dump_issue;
        mem.raddr = ring_idx(front_r, k_r);
        if (dump_issue) begin
          k_nxt    = k_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (dump_load) begin
          pend_nxt = 1'b0;
        end
        res.load   = dump_load;
        res.item   = rd_data;
        res.status = STAT_OK;
        res.last   = dump_last;
      end
      ST_RESP: begin
        res.load   = out_free;
        res.status = status_r;
        res.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      occ_r    <= '0;
      k_r      <= '0;
      pend_r   <= 1'b0;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      occ_r    <= occ_nxt;
      k_r      <= k_nxt;
      pend_r   <= pend_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

@@ design/bounded_deque_with_indexed_delete_core.sv @@
// Bounded deque of signed words with indexed delete, stream interface.
//
// The list holds up to 16 words in a ring of slots in one dual-port RAM.
// A command is taken when in_tready is high, which is whenever no earlier
// command is still running; a finished result may still be waiting on the
// output then. Inserts and rejected commands go straight to a response
// state. A delete at position p moves each later element down one slot,
// one slot moved per cycle through the RAM's read and write ports. A dump
// starts the first slot read, then reads one slot per cycle while the
// output register is free. Every result waits for the output register to
// drain on out_tready.
// Every command returns one result, except a non-empty dump, which returns
// one result per element, front to back, with out_tlast on the final one.
module bounded_deque_with_indexed_delete_core import bdq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], position[39:32]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // item[31:0], length[36:32], zero pad
  output logic [STAT_W-1:0]      out_tuser,  // status[1:0]
  output logic                   out_tlast
);

  result_t                  res;
  mem_req_t                 mem;
  logic [DATA_W-1:0]        rd_data;
  logic                     out_free;
  logic signed [DATA_W-1:0] out_item;
  status_t                  out_status;
  logic [LEN_W-1:0]         out_length;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (cmd_t'(in_tuser)),
    .in_value (in_tdata[DATA_W-1:0]),
    .in_pos   (in_tdata[DATA_W+POS_W-1:DATA_W]),
    .out_free (out_free),
    .res      (res),
    .mem      (mem),
    .rd_data  (rd_data)
  );

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

  bdq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item),
    .out_status (out_status),
    .out_length (out_length),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_length, out_item};
  assign out_tuser = out_status;

endmodule

@@ design/bdq_checker.sv @@
// Port-level assertions for the deque core, bound to the top level.
module bdq_checker import bdq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser,
  input logic                   out_tlast
);

  // A stalled result transaction holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // The count never goes past capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_W+LEN_W-1:DATA_W] <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  // Only dump results carry data and come in runs; any error ends the command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tlast && out_tdata[DATA_W-1:0] == '0)
    else $error("error result not final or carries data");

  // Within a dump run the reported count stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
      out_tdata[DATA_W+LEN_W-1:DATA_W] == $past(out_tdata[DATA_W+LEN_W-1:DATA_W]))
    else $error("length changed during dump");

endmodule

bind bounded_deque_with_indexed_delete_core bdq_checker u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ dv/bounded_deque_with_indexed_delete_core_test.sv @@
// Testbench for the bounded deque core: directed and random commands checked by a scoreboard.
module bounded_deque_with_indexed_delete_core_test import bdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS = 40;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [DATA_W-1:0] item;
    status_t                  status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } deque_result_t;

  // Tracks the list contents and the results each command must produce.
  class deque_tracker;
    logic signed [DATA_W-1:0] contents[$];
    deque_result_t            due_results[$];
    int                       errors;

    function void add_result(logic signed [DATA_W-1:0] item, status_t status, logic last);
      deque_result_t r;
      r.item   = item;
      r.status = status;
      r.length = LEN_W'(contents.size());
      r.last   = last;
      due_results.push_back(r);
    endfunction

    function void apply_command(cmd_t op, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
      case (op)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (contents.size() >= CAPACITY) begin
            add_result('0, STAT_FULL, 1'b1);
          end else begin
            if (op == CMD_INS_FRONT) contents.push_front(value);
            else contents.push_back(value);
            add_result('0, STAT_OK, 1'b1);
          end
        end
        CMD_DELETE: begin
          if (contents.size() == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else if (int'(pos) >= contents.size()) begin
            add_result('0, STAT_RANGE, 1'b1);
          end else begin
            contents.delete(int'(pos));
            add_result('0, STAT_OK, 1'b1);
          end
        end
        default: begin
          if (contents.size() == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            foreach (contents[k]) add_result(contents[k], STAT_OK, k == contents.size() - 1);
          end
        end
      endcase
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] item, status_t status,
                               logic [LEN_W-1:0] length, logic last);
      deque_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual item %0d status %0d length %0d last %0d",
                 $time, item, status, length, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("item", want.item, item);
      compare_field("status", want.status, status);
      compare_field("length", want.length, length);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // value[31:0], position[39:32]
  logic [CMD_W-1:0]       in_tuser = '0;   // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // item[31:0], length[36:32], zero pad
  logic [STAT_W-1:0]      out_tuser;       // status[1:0]
  logic                   out_tlast;

  deque_tracker tracker = new();
  bit           idle_on = 1'b1;
  int           stall_left = 0;
  int           quiet_cycles = 0;

  bounded_deque_with_indexed_delete_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive one command and hold it until the transaction completes.
  task automatic send_command(input cmd_t op, input logic signed [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({pos, value});
    do @(posedge clk); while (!in_tready);
    tracker.apply_command(op, value, pos);
  endtask

  // Result side back-pressure in short random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (rst_n && idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata[DATA_W-1:0], status_t'(out_tuser),
                           out_tdata[DATA_W +: LEN_W], out_tlast);
    end
  end

  // Abort when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("bounded_deque_with_indexed_delete_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int   pick;
    bit   growing;
    cmd_t op;
    logic [POS_W-1:0] pos;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list cases, extremes, fill to full, reject, deletes.
    send_command(CMD_DUMP, $urandom, POS_W'($urandom_range(0, 255)));
    send_command(CMD_DELETE, $urandom, 8'd0);
    send_command(CMD_INS_FRONT, 32'sh8000_0000, 8'hff);
    send_command(CMD_INS_BACK, 32'sh7fff_ffff, 8'h00);
    for (int i = 0; i < CAPACITY - 2; i++) begin
      send_command((i % 2 == 0) ? CMD_INS_FRONT : CMD_INS_BACK, $urandom,
                   POS_W'($urandom_range(0, 255)));
    end
    send_command(CMD_INS_FRONT, 32'sh0000_0000, 8'd0);
    send_command(CMD_INS_BACK, 32'shffff_ffff, 8'd0);
    send_command(CMD_DUMP, $urandom, POS_W'($urandom_range(0, 255)));
    send_command(CMD_DELETE, $urandom, 8'd255);
    send_command(CMD_DELETE, $urandom, 8'(CAPACITY));
    send_command(CMD_DELETE, $urandom, 8'(CAPACITY - 1));
    send_command(CMD_DELETE, $urandom, 8'd0);
    send_command(CMD_DELETE, $urandom, 8'd5);
    send_command(CMD_DUMP, $urandom, POS_W'($urandom_range(0, 255)));

    // Random: alternate growing and shrinking phases so full and empty both recur.
    growing = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) growing = !growing;
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (growing) begin
        if (pick < 35) op = CMD_INS_FRONT;
        else if (pick < 70) op = CMD_INS_BACK;
        else if (pick < 85) op = CMD_DELETE;
        else op = CMD_DUMP;
      end else begin
        if (pick < 15) op = CMD_INS_FRONT;
        else if (pick < 30) op = CMD_INS_BACK;
        else if (pick < 85) op = CMD_DELETE;
        else op = CMD_DUMP;
      end
      if ($urandom_range(0, 99) < 85 && tracker.contents.size() > 0) begin
        pos = POS_W'($urandom_range(0, tracker.contents.size() - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 255));
      end
      send_command(op, $urandom, pos);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("bounded_deque_with_indexed_delete_core test passed");
    end else begin
      $display("bounded_deque_with_indexed_delete_core test failed");
    end
    $finish;
  end

endmodule
